// File: rtl/ps2hb_pkg.sv
// Shared types and constants for the PS/2 host bit engine.
package ps2hb_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned FrameW    = 16;
  localparam int unsigned CountW    = 4;
  localparam int unsigned TimeoutW  = 8;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 32;

  localparam logic [CountW-1:0]   FRAME_EDGES      = 4'd12;
  localparam logic [CountW-1:0]   FIRST_SEND_COUNT = 4'd11;
  localparam logic [CountW-1:0]   LAST_COUNT       = 4'd1;
  localparam logic [CountW-1:0]   IDLE_COUNT       = 4'd0;
  localparam logic [TimeoutW-1:0] TIMEOUT_RESET    = 8'd20;

  typedef enum logic [CmdW-1:0] {
    CMD_EDGE       = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_START_RECV = 2'd2,
    CMD_START_SEND = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic              data_pin;
    logic [FrameW-1:0] send_frame;
  } item_t;

  typedef struct packed {
    logic              sending;
    logic              timed_out;
    logic [FrameW-1:0] received_word;
    logic [CountW-1:0] edges_left;
    logic              data_output_enable;
    logic              data_drive;
    logic              clock_hold_low;
  } result_t;

endpackage

// File: rtl/ps2_host_bit_engine.sv
// Top level of the PS/2 host bit engine: input stage, state update and result register.
//
//   Channel | Direction | Contents
//   in_     | slave     | one event request: edge, tick, start receive, start send
//   out_    | master    | channel status after the event
//   cfg_    | write     | timeout reload value
//
// One request is accepted per cycle while out_ is not stalled; a request passes the input
// register and then the state update, which loads its result into the result register to be offered.
// Reset is synchronous and active low; it clears the channel state and sets the reload to 20.
// A stalled result holds the result register, and the input register then holds one more
// request before in_tready falls.
module ps2_host_bit_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_pin [0], send_frame [16:1], zero [23:17]
  input  logic [1:0]  in_tuser,   // command [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // clock_hold_low [0], data_drive [1], data_output_enable [2],
                                  // edges_left [6:3], received_word [22:7], timed_out [23],
                                  // sending [24], zero [31:25]
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import ps2hb_pkg::*;

  logic    item_valid;
  logic    item_ready;
  item_t   item;
  result_t res;

  ps2hb_input_stage u_input (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_command    (in_tuser),
    .in_data_pin   (in_tdata[0]),
    .in_send_frame (in_tdata[16:1]),
    .item_valid    (item_valid),
    .item          (item),
    .item_ready    (item_ready)
  );

  ps2hb_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .res_valid  (out_tvalid),
    .res        (res),
    .res_ready  (out_tready)
  );

  assign out_tdata = {7'd0, res};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.edges_left <= FRAME_EDGES))
    else $error("edges_left exceeds a full frame");

  a_drive_in_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.data_output_enable) |-> res.sending)
    else $error("data driver enabled outside send mode");

  a_timeout_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.timed_out) |-> (res.edges_left != IDLE_COUNT))
    else $error("timeout reported while idle");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid) |-> item_ready)
    else $error("core stalled with an empty result register");
`endif

endmodule

// File: rtl/ps2hb_input_stage.sv
// Input register stage that captures one request from the input stream.
module ps2hb_input_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ps2hb_pkg::CmdW-1:0]   in_command,
  input  logic                         in_data_pin,
  input  logic [ps2hb_pkg::FrameW-1:0] in_send_frame,
  output logic                         item_valid,
  output ps2hb_pkg::item_t             item,
  input  logic                         item_ready
);
  import ps2hb_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_tready  = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.command    <= in_command;
      item_r.data_pin   <= in_data_pin;
      item_r.send_frame <= in_send_frame;
    end
  end

endmodule

// File: rtl/ps2hb_core.sv
// Channel state update and result register of the PS/2 host bit engine.
module ps2hb_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ps2hb_pkg::TimeoutW-1:0] cfg_wdata,
  input  logic                           item_valid,
  input  ps2hb_pkg::item_t               item,
  output logic                           item_ready,
  output logic                           res_valid,
  output ps2hb_pkg::result_t             res,
  input  logic                           res_ready
);
  import ps2hb_pkg::*;

  logic [TimeoutW-1:0] reload_r;
  logic                send_mode_r, send_mode_nxt;
  logic [CountW-1:0]   count_r, count_nxt;
  logic [FrameW-1:0]   shift_r, shift_nxt;
  logic [TimeoutW-1:0] tleft_r, tleft_nxt;
  logic                held_r, held_nxt;
  logic                level_r, level_nxt;
  logic                enabled_r, enabled_nxt;
  logic                res_valid_r, res_valid_nxt;
  result_t             res_r;
  logic [CountW-1:0]   count_dec;
  logic                take;

  assign item_ready = !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;
  assign count_dec  = count_r - 1'b1;

  always_comb begin
    send_mode_nxt = send_mode_r;
    count_nxt     = count_r;
    shift_nxt     = shift_r;
    tleft_nxt     = tleft_r;
    held_nxt      = held_r;
    level_nxt     = level_r;
    enabled_nxt   = enabled_r;
    case (cmd_t'(item.command))
      CMD_EDGE: begin
        if (count_r != IDLE_COUNT) begin
          tleft_nxt = reload_r;
          count_nxt = count_dec;
          if (send_mode_r) begin
            if (count_dec != IDLE_COUNT) begin
              level_nxt = shift_r[0];
              shift_nxt = {1'b0, shift_r[FrameW-1:1]};
              if (count_dec == FIRST_SEND_COUNT) begin
                enabled_nxt = 1'b1;
              end else if (count_dec == LAST_COUNT) begin
                enabled_nxt = 1'b0;
              end
            end else begin
              held_nxt = 1'b1;
            end
          end else begin
            shift_nxt = {item.data_pin, shift_r[FrameW-1:1]};
            if (count_dec == LAST_COUNT) begin
              held_nxt  = 1'b1;
              count_nxt = IDLE_COUNT;
            end
          end
        end
      end
      CMD_TICK: begin
        if (count_r != IDLE_COUNT && count_r < FRAME_EDGES) begin
          if (send_mode_r && count_r == FIRST_SEND_COUNT && tleft_r < reload_r) begin
            held_nxt = 1'b0;
          end
          if (tleft_r != '0) begin
            tleft_nxt = tleft_r - 1'b1;
          end
        end
      end
      CMD_START_RECV: begin
        send_mode_nxt = 1'b0;
        count_nxt     = FRAME_EDGES;
        held_nxt      = 1'b0;
        enabled_nxt   = 1'b0;
        level_nxt     = 1'b1;
        tleft_nxt     = reload_r;
      end
      CMD_START_SEND: begin
        send_mode_nxt = 1'b1;
        count_nxt     = FRAME_EDGES;
        shift_nxt     = item.send_frame;
        held_nxt      = 1'b1;
        tleft_nxt     = reload_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (item_ready) begin
      res_valid_nxt = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r    <= TIMEOUT_RESET;
      send_mode_r <= 1'b0;
      count_r     <= IDLE_COUNT;
      shift_r     <= '0;
      tleft_r     <= '0;
      held_r      <= 1'b0;
      level_r     <= 1'b1;
      enabled_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        reload_r <= cfg_wdata;
      end
      if (take) begin
        send_mode_r <= send_mode_nxt;
        count_r     <= count_nxt;
        shift_r     <= shift_nxt;
        tleft_r     <= tleft_nxt;
        held_r      <= held_nxt;
        level_r     <= level_nxt;
        enabled_r   <= enabled_nxt;
      end
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r.clock_hold_low     <= held_nxt;
      res_r.data_drive         <= level_nxt;
      res_r.data_output_enable <= enabled_nxt;
      res_r.edges_left         <= count_nxt;
      res_r.received_word      <= shift_nxt;
      res_r.timed_out          <= (count_nxt != IDLE_COUNT) && (tleft_nxt == '0);
      res_r.sending            <= send_mode_nxt;
    end
  end

endmodule
